// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, request and status codes, and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam int unsigned MAP_PAGES_DEF  = 4096;
    localparam int unsigned PAGE_BYTES_DEF = 4096;

    localparam int unsigned REQ_W          = 3;
    localparam int unsigned PAGE_IDX_W     = 12;
    localparam int unsigned RUN_LEN_W      = 13;
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned PAGE_COUNT_W   = 13;
    localparam int unsigned BASE_PAGE_W    = 20;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned BIT_W          = 5;

    localparam int unsigned S_DATA_W       = 32;
    localparam int unsigned M_DATA_W       = 48;
    localparam int unsigned CFG_ADDR_W     = 1;
    localparam int unsigned CFG_DATA_W     = 20;

    localparam logic [REQ_W-1:0] REQ_FREE     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RESERVE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ALLOC    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND_RUN = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ARG = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_PAGE  = 1'd1;

    localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RST = 13'd4096;
    localparam logic [BASE_PAGE_W-1:0]  BASE_PAGE_RST  = 20'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_ADDR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== src/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/bitmap_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator core
// One-bit-per-page used map in a RAM, with free, reserve, allocate-first,
// query and find-run requests.
// ----------------------------------------------------------------------------
// After reset the map RAM is cleared one word per cycle while in ST_CLEAR,
// and s_tready stays low during that pass. Requests are handled one at a time.
// Free, reserve and query read the map word when accepted; in ST_RMW free and
// reserve write it back and query samples the page bit, and ST_DONE loads the
// result register once the output is free. Allocate-first and find-run scan
// the map through the RAM read port one 32-bit word per cycle up to the page
// count limit, ending early at the first hit. A finished result waits in the
// output register while the next request is accepted.
`default_nettype none

module bitmap_page_allocator_core #(
    parameter int unsigned MAP_PAGES  = bpa_pkg::MAP_PAGES_DEF,
    parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // page_index [11:0], run_length [24:12], zero [31:25]
    input  wire logic [bpa_pkg::S_DATA_W-1:0]      s_tdata,
    // req_type [2:0]
    input  wire logic [bpa_pkg::REQ_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // result_index [11:0], result_addr [43:12], page_free [44], zero [47:45]
    output logic      [bpa_pkg::M_DATA_W-1:0]      m_tdata,
    // status [1:0]
    output logic      [bpa_pkg::STATUS_W-1:0]      m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [bpa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import bpa_pkg::*;

    localparam int unsigned MAP_WORDS = MAP_PAGES / WORD_W;
    localparam int unsigned WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned IDX_W     = ($clog2(MAP_PAGES) + 1 > PAGE_COUNT_W) ?
                                        $clog2(MAP_PAGES) + 1 : PAGE_COUNT_W;
    localparam logic [IDX_W-1:0]   MAP_PAGES_C  = IDX_W'(MAP_PAGES);
    localparam logic [WADDR_W-1:0] LAST_WORD    = WADDR_W'(MAP_WORDS - 1);
    localparam logic [ADDR_W-1:0]  PAGE_BYTES_C = ADDR_W'(PAGE_BYTES);

    state_t state_reg, state_next, accept_state;

    logic [PAGE_COUNT_W-1:0] page_count_reg;
    logic [BASE_PAGE_W-1:0]  base_page_reg;
    logic [WADDR_W-1:0]      clr_reg;
    logic                    m_tvalid_reg;

    logic [REQ_W-1:0]        req_reg;
    logic [PAGE_IDX_W-1:0]   idx_reg;
    logic [RUN_LEN_W-1:0]    len_reg;
    logic [WADDR_W-1:0]      cur_reg;
    logic [IDX_W-1:0]        streak_reg;
    logic [IDX_W-1:0]        res_idx_reg;
    logic                    found_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic                    pfree_reg;
    logic [ADDR_W-1:0]       sum_reg;
    logic [STATUS_W-1:0]     m_status_reg;
    logic [PAGE_IDX_W-1:0]   m_index_reg;
    logic [ADDR_W-1:0]       m_addr_reg;
    logic                    m_free_reg;

    logic                    ram_we;
    logic [WADDR_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic [WADDR_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]       ram_rdata;

    logic [IDX_W-1:0]        limit;
    logic [PAGE_IDX_W-1:0]   s_index;
    logic [RUN_LEN_W-1:0]    s_len;
    logic [STATUS_W-1:0]     accept_status;
    logic                    in_accept;
    logic                    out_free;
    logic [WORD_W-1:0]       page_mask;

    logic [IDX_W-1:0]        word_base;
    logic [IDX_W-1:0]        run_len [WORD_W];
    logic [BIT_W:0]          last_used;
    logic                    any_used;
    logic [WORD_W-1:0]       alloc_ok;
    logic [WORD_W-1:0]       run_ok;
    logic [WORD_W-1:0]       cand;
    logic                    hit;
    logic [BIT_W-1:0]        hit_pos;
    logic                    word_end;
    logic [IDX_W-1:0]        hit_index;

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign limit = (IDX_W'(page_count_reg) > MAP_PAGES_C) ? MAP_PAGES_C
                                                         : IDX_W'(page_count_reg);
    assign s_index   = s_tdata[PAGE_IDX_W-1:0];
    assign s_len     = s_tdata[PAGE_IDX_W +: RUN_LEN_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign page_mask = WORD_W'(1) << idx_reg[BIT_W-1:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_free_reg, m_addr_reg, m_index_reg};

    always_comb begin
        accept_state  = ST_DONE;
        accept_status = STATUS_OK;
        unique case (s_tuser) inside
            REQ_FREE, REQ_RESERVE, REQ_QUERY: begin
                if (IDX_W'(s_index) >= limit) begin
                    accept_status = STATUS_BAD_ARG;
                end else begin
                    accept_state = ST_RMW;
                end
            end
            REQ_ALLOC: begin
                if (limit == '0) begin
                    accept_status = STATUS_NONE;
                end else begin
                    accept_state = ST_SCAN;
                end
            end
            REQ_FIND_RUN: begin
                if (s_len == '0) begin
                    accept_status = STATUS_BAD_ARG;
                end else if (limit == '0) begin
                    accept_status = STATUS_NONE;
                end else begin
                    accept_state = ST_SCAN;
                end
            end
            default: begin
                accept_status = STATUS_BAD_ARG;
            end
        endcase
    end

    always_comb begin
        word_base = IDX_W'({cur_reg, {BIT_W{1'b0}}});
        last_used = '0;
        any_used  = 1'b0;
        for (int b = 0; b < WORD_W; b++) begin
            if (ram_rdata[b]) begin
                last_used = (BIT_W + 1)'(b + 1);
                any_used  = 1'b1;
            end
            run_len[b] = any_used ? IDX_W'(b + 1) - IDX_W'(last_used)
                                  : streak_reg + IDX_W'(b + 1);
            alloc_ok[b] = ((word_base + IDX_W'(b)) < limit) && !ram_rdata[b];
            run_ok[b]   = alloc_ok[b] && (run_len[b] >= IDX_W'(len_reg));
        end
        cand    = (req_reg == REQ_ALLOC) ? alloc_ok : run_ok;
        hit     = |cand;
        hit_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                hit_pos = BIT_W'(b);
            end
        end
        word_end  = (word_base + IDX_W'(WORD_W)) >= limit;
        hit_index = (req_reg == REQ_ALLOC) ? word_base + IDX_W'(hit_pos)
                  : word_base + IDX_W'(hit_pos) + IDX_W'(1) - IDX_W'(len_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = accept_state;
                end
            end
            ST_RMW: begin
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = ST_ADDR;
                end else if (word_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_ADDR: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = ram_rdata;
        ram_raddr = cur_reg + WADDR_W'(1);
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                if (s_tuser == REQ_ALLOC || s_tuser == REQ_FIND_RUN) begin
                    ram_raddr = '0;
                end else begin
                    ram_raddr = WADDR_W'(s_index[PAGE_IDX_W-1:BIT_W]);
                end
            end
            ST_RMW: begin
                ram_waddr = WADDR_W'(idx_reg[PAGE_IDX_W-1:BIT_W]);
                ram_we    = (req_reg == REQ_FREE) || (req_reg == REQ_RESERVE);
                ram_wdata = (req_reg == REQ_RESERVE) ? (ram_rdata | page_mask)
                                                     : (ram_rdata & ~page_mask);
            end
            ST_SCAN: begin
                ram_we    = hit && (req_reg == REQ_ALLOC);
                ram_wdata = ram_rdata | (WORD_W'(1) << hit_pos);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            page_count_reg <= PAGE_COUNT_RST;
            base_page_reg  <= BASE_PAGE_RST;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + WADDR_W'(1);
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_PAGE_COUNT: page_count_reg <= cfg_wdata[PAGE_COUNT_W-1:0];
                    CFG_BASE_PAGE:  base_page_reg  <= cfg_wdata[BASE_PAGE_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            req_reg     <= s_tuser;
            idx_reg     <= s_index;
            len_reg     <= s_len;
            cur_reg     <= '0;
            streak_reg  <= '0;
            res_idx_reg <= '0;
            found_reg   <= 1'b0;
            pfree_reg   <= 1'b0;
            status_reg  <= accept_status;
        end
        if (state_reg == ST_RMW && req_reg == REQ_QUERY) begin
            pfree_reg <= !ram_rdata[idx_reg[BIT_W-1:0]];
        end
        if (state_reg == ST_SCAN) begin
            if (hit) begin
                found_reg   <= 1'b1;
                res_idx_reg <= hit_index;
                status_reg  <= STATUS_OK;
            end else if (word_end) begin
                status_reg <= STATUS_NONE;
            end else begin
                cur_reg    <= cur_reg + WADDR_W'(1);
                streak_reg <= run_len[WORD_W-1];
            end
        end
        if (state_reg == ST_ADDR) begin
            sum_reg <= ADDR_W'(base_page_reg) + ADDR_W'(res_idx_reg);
        end
        if (state_reg == ST_DONE && out_free) begin
            m_status_reg <= status_reg;
            m_index_reg  <= res_idx_reg[PAGE_IDX_W-1:0];
            m_addr_reg   <= found_reg ? sum_reg * PAGE_BYTES_C : '0;
            m_free_reg   <= pfree_reg;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_bitmap_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator core testbench
// Drives free, reserve, allocate, query and run-search transactions into the
// core and checks each response against a page-map model or a table value.
// A directed table covers the corner cases, then random traffic runs under
// several page-count and base-page settings with random stalls on both sides.
// ----------------------------------------------------------------------------

module tb_bitmap_page_allocator_core;

    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN_MIN = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_MAX = 3'd7;

    localparam int unsigned MAP_WORDS        = MAP_PAGES_DEF / WORD_W;
    localparam int unsigned SETTLE_CYCLES    = 2 * MAP_WORDS + 8;
    localparam int unsigned LONG_HOLD_AFTER  = 250;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam longint      TIMEOUT_NS       = 64'd15_000_000;

    typedef struct packed {
        logic [REQ_W-1:0]      kind;
        logic [PAGE_IDX_W-1:0] index;
        logic [RUN_LEN_W-1:0]  length;
    } page_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PAGE_IDX_W-1:0] index;
        logic [ADDR_W-1:0]     addr;
        logic                  page_free;
    } page_resp_t;

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_KNOWN,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             row;
        logic [REQ_W-1:0]      kind;
        logic [PAGE_IDX_W-1:0] index;
        logic [RUN_LEN_W-1:0]  length;
        logic [CFG_ADDR_W-1:0] reg_sel;
        logic [CFG_DATA_W-1:0] value;
        page_resp_t            resp;
    } step_t;

    localparam page_resp_t RESP_OK   = '{STATUS_OK, 12'd0, 32'd0, 1'b0};
    localparam page_resp_t RESP_FREE = '{STATUS_OK, 12'd0, 32'd0, 1'b1};
    localparam page_resp_t RESP_NONE = '{STATUS_NONE, 12'd0, 32'd0, 1'b0};
    localparam page_resp_t RESP_BAD  = '{STATUS_BAD_ARG, 12'd0, 32'd0, 1'b0};

    localparam int NUM_STEPS = 32;
    localparam step_t DIRECTED_STEPS [NUM_STEPS] = '{
        '{ROW_KNOWN, REQ_ALLOC, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_ALLOC, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0,
          '{STATUS_OK, 12'd1, 32'd4096, 1'b0}},
        '{ROW_KNOWN, REQ_QUERY, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_QUERY, 12'd4095, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_FREE},
        '{ROW_KNOWN, REQ_RESERVE, 12'd4095, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_RESERVE, 12'd4095, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_QUERY, 12'd4095, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_FREE, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_FREE, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_FIND_RUN, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_BAD},
        '{ROW_KNOWN, REQ_FIND_RUN, 12'd0, 13'd1, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_FIND_RUN, 12'd0, 13'd4096, CFG_PAGE_COUNT, 20'd0, RESP_NONE},
        '{ROW_KNOWN, REQ_FIND_RUN, 12'd0, 13'd8191, CFG_PAGE_COUNT, 20'd0, RESP_NONE},
        '{ROW_PREDICTED, REQ_FIND_RUN, 12'd0, 13'd4093, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_UNKNOWN_MIN, 12'd4095, 13'd8191, CFG_PAGE_COUNT, 20'd0, RESP_BAD},
        '{ROW_KNOWN, REQ_UNKNOWN_MAX, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_BAD},
        '{ROW_PREDICTED, REQ_ALLOC, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_CONFIG, REQ_FREE, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_KNOWN, REQ_ALLOC, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_NONE},
        '{ROW_KNOWN, REQ_FIND_RUN, 12'd0, 13'd1, CFG_PAGE_COUNT, 20'd0, RESP_NONE},
        '{ROW_KNOWN, REQ_QUERY, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_BAD},
        '{ROW_KNOWN, REQ_FREE, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_BAD},
        '{ROW_CONFIG, REQ_FREE, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd8191, RESP_OK},
        '{ROW_CONFIG, REQ_FREE, 12'd0, 13'd0, CFG_BASE_PAGE, 20'd1048575, RESP_OK},
        '{ROW_PREDICTED, REQ_ALLOC, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_PREDICTED, REQ_QUERY, 12'd2048, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_CONFIG, REQ_FREE, 12'd0, 13'd0, CFG_PAGE_COUNT, 20'd100, RESP_OK},
        '{ROW_KNOWN, REQ_RESERVE, 12'd100, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_BAD},
        '{ROW_KNOWN, REQ_QUERY, 12'd4095, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_BAD},
        '{ROW_PREDICTED, REQ_FIND_RUN, 12'd0, 13'd100, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_PREDICTED, REQ_RESERVE, 12'd99, 13'd0, CFG_PAGE_COUNT, 20'd0, RESP_OK},
        '{ROW_PREDICTED, REQ_FIND_RUN, 12'd0, 13'd96, CFG_PAGE_COUNT, 20'd0, RESP_OK}
    };

    localparam int NUM_PHASES = 8;
    localparam logic [PAGE_COUNT_W-1:0] PHASE_PAGES [NUM_PHASES] = '{
        13'd64, 13'd4096, 13'd33, 13'd0, 13'd8191, 13'd1, 13'd500, 13'd4096
    };
    localparam logic [BASE_PAGE_W-1:0] PHASE_BASE [NUM_PHASES] = '{
        20'h00001, 20'h00000, 20'hFFFFF, 20'h12345, 20'hFFF00, 20'h54321, 20'h0ABCD,
        20'h80000
    };
    localparam int unsigned PHASE_ITEMS [NUM_PHASES] = '{
        150, 180, 150, 60, 150, 120, 180, 200
    };

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata;
    logic [REQ_W-1:0]        s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_DATA_W-1:0]     m_tdata;
    logic [STATUS_W-1:0]     m_tuser;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    bit                      page_is_used [MAP_PAGES_DEF];
    logic [PAGE_COUNT_W-1:0] pages_tracked = PAGE_COUNT_RST;
    logic [BASE_PAGE_W-1:0]  base_page     = BASE_PAGE_RST;

    page_resp_t              pending_responses [$];
    page_resp_t              oldest_expected;
    int unsigned             error_count       = 0;
    int unsigned             responses_checked = 0;
    int unsigned             kind_count [2**REQ_W];
    int unsigned             none_count        = 0;
    int unsigned             bad_count         = 0;
    int unsigned             register_writes   = 0;
    bit                      quiet             = 1'b0;
    bit                      long_hold_done    = 1'b0;

    bitmap_page_allocator_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned tracked_limit();
        return (pages_tracked > MAP_PAGES_DEF) ? MAP_PAGES_DEF : pages_tracked;
    endfunction

    // Applies one request to the page map and returns the response it should produce.
    function automatic page_resp_t predict_response(input page_req_t req);
        page_resp_t  resp;
        int unsigned lim;
        int unsigned run;
        bit          found;
        resp  = '0;
        found = 1'b0;
        run   = 0;
        lim   = tracked_limit();
        case (req.kind) inside
            REQ_FREE, REQ_RESERVE, REQ_QUERY: begin
                if (req.index >= lim) begin
                    resp.status = STATUS_BAD_ARG;
                end else if (req.kind == REQ_QUERY) begin
                    resp.page_free = !page_is_used[req.index];
                end else begin
                    page_is_used[req.index] = (req.kind == REQ_RESERVE);
                end
            end
            REQ_ALLOC: begin
                for (int unsigned i = 0; i < lim && !found; i++) begin
                    if (!page_is_used[i]) begin
                        page_is_used[i] = 1'b1;
                        resp.index      = PAGE_IDX_W'(i);
                        found           = 1'b1;
                    end
                end
                resp.status = found ? STATUS_OK : STATUS_NONE;
            end
            REQ_FIND_RUN: begin
                if (req.length == 0) begin
                    resp.status = STATUS_BAD_ARG;
                end else begin
                    for (int unsigned i = 0; i < lim && !found; i++) begin
                        run = page_is_used[i] ? 0 : run + 1;
                        if (run == req.length) begin
                            resp.index = PAGE_IDX_W'(i + 1 - run);
                            found      = 1'b1;
                        end
                    end
                    resp.status = found ? STATUS_OK : STATUS_NONE;
                end
            end
            default: begin
                resp.status = STATUS_BAD_ARG;
            end
        endcase
        if (found) begin
            resp.addr = ADDR_W'((64'(base_page) + 64'(resp.index)) * PAGE_BYTES_DEF);
        end
        return resp;
    endfunction

    // Mostly in-range traffic biased toward allocation and freeing of pages
    // in use, with some out-of-range indexes, odd run lengths and unknown types.
    function automatic page_req_t random_request();
        page_req_t   req;
        int unsigned lim;
        int unsigned pick;
        int unsigned sub;
        int unsigned start;
        lim        = tracked_limit();
        pick       = $urandom_range(0, 99);
        req.kind   = REQ_ALLOC;
        req.index  = PAGE_IDX_W'($urandom_range(0, MAP_PAGES_DEF - 1));
        req.length = RUN_LEN_W'($urandom_range(1, 12));
        if (lim != 0 && pick < 95) begin
            req.index = PAGE_IDX_W'($urandom_range(0, lim - 1));
        end
        if (pick < 30) begin
            req.kind = REQ_ALLOC;
        end else if (pick < 55) begin
            req.kind = REQ_FREE;
            if (lim != 0 && pick < 45) begin
                start = $urandom_range(0, lim - 1);
                for (int unsigned j = 0; j < lim; j++) begin
                    if (page_is_used[(start + j) % lim]) begin
                        req.index = PAGE_IDX_W'((start + j) % lim);
                        break;
                    end
                end
            end
        end else if (pick < 67) begin
            req.kind = REQ_RESERVE;
        end else if (pick < 79) begin
            req.kind = REQ_QUERY;
        end else if (pick < 94) begin
            req.kind = REQ_FIND_RUN;
            sub      = $urandom_range(0, 9);
            if (sub == 9) begin
                req.length = $urandom_range(0, 1) ? '0
                                                  : RUN_LEN_W'($urandom_range(0, 8191));
            end else if (sub >= 7) begin
                req.length = RUN_LEN_W'($urandom_range(1, lim + 1));
            end
        end else if (pick < 97) begin
            req.kind   = REQ_W'($urandom_range(REQ_UNKNOWN_MIN, REQ_UNKNOWN_MAX));
            req.length = RUN_LEN_W'($urandom_range(0, 8191));
        end else begin
            req.kind   = REQ_W'($urandom_range(0, 2**REQ_W - 1));
            req.index  = PAGE_IDX_W'($urandom_range(0, MAP_PAGES_DEF - 1));
            req.length = RUN_LEN_W'($urandom_range(0, 8191));
        end
        return req;
    endfunction

    task automatic send_request(input page_req_t req, input bit known,
                                input page_resp_t known_resp);
        page_resp_t          resp;
        logic [S_DATA_W-1:0] word;
        word                          = '0;
        word[PAGE_IDX_W-1:0]          = req.index;
        word[PAGE_IDX_W +: RUN_LEN_W] = req.length;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= req.kind;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        resp = predict_response(req);
        if (known) begin
            resp = known_resp;
        end
        pending_responses.push_back(resp);
        kind_count[req.kind]++;
        if (resp.status == STATUS_NONE) begin
            none_count++;
        end else if (resp.status == STATUS_BAD_ARG) begin
            bad_count++;
        end
    endtask

    task automatic pause_sender();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic wait_for_responses();
        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] sel,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= sel;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (sel == CFG_PAGE_COUNT) begin
            pages_tracked = value[PAGE_COUNT_W-1:0];
        end else begin
            base_page = value[BASE_PAGE_W-1:0];
        end
        register_writes++;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_responses.size() == 0) begin
                $error("Unexpected response: status %0d, data %h", m_tuser, m_tdata);
                error_count++;
            end else begin
                oldest_expected = pending_responses.pop_front();
                if (m_tuser !== oldest_expected.status) begin
                    $error("status: expected %0d, got %0d", oldest_expected.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[PAGE_IDX_W-1:0] !== oldest_expected.index) begin
                    $error("result_index: expected %0d, got %0d", oldest_expected.index,
                           m_tdata[PAGE_IDX_W-1:0]);
                    error_count++;
                end
                if (m_tdata[PAGE_IDX_W +: ADDR_W] !== oldest_expected.addr) begin
                    $error("result_addr: expected %h, got %h", oldest_expected.addr,
                           m_tdata[PAGE_IDX_W +: ADDR_W]);
                    error_count++;
                end
                if (m_tdata[PAGE_IDX_W + ADDR_W] !== oldest_expected.page_free) begin
                    $error("page_free: expected %0d, got %0d", oldest_expected.page_free,
                           m_tdata[PAGE_IDX_W + ADDR_W]);
                    error_count++;
                end
                responses_checked++;
            end
        end
    end

    initial begin : result_sink
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!long_hold_done && responses_checked >= LONG_HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        step_t     row;
        page_req_t req;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_FREE;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_PAGE_COUNT;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_STEPS; i++) begin
            row = DIRECTED_STEPS[i];
            if (row.row == ROW_CONFIG) begin
                wait_for_responses();
                write_register(row.reg_sel, row.value);
            end else begin
                req = '{row.kind, row.index, row.length};
                pause_sender();
                send_request(req, row.row == ROW_KNOWN, row.resp);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_responses();
            write_register(CFG_PAGE_COUNT, CFG_DATA_W'(PHASE_PAGES[p]));
            write_register(CFG_BASE_PAGE, PHASE_BASE[p]);
            quiet = (p == NUM_PHASES - 1);
            for (int unsigned n = 0; n < PHASE_ITEMS[p]; n++) begin
                pause_sender();
                send_request(random_request(), 1'b0, RESP_OK);
            end
        end

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d allocate, %0d free, %0d reserve, %0d query and %0d run-search %s",
                 kind_count[REQ_ALLOC], kind_count[REQ_FREE], kind_count[REQ_RESERVE],
                 kind_count[REQ_QUERY], kind_count[REQ_FIND_RUN], "transactions.");
        $display("Checked %0d responses (%0d nothing found, %0d bad argument) over %0d %s",
                 responses_checked, none_count, bad_count, register_writes,
                 "register writes.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $error("Timed out with %0d responses outstanding.", pending_responses.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bpa_pkg.sv
src/bpa_ram.sv
src/bitmap_page_allocator_core.sv
tb/tb_bitmap_page_allocator_core.sv
